// ===== rtl/core/seg7d_pkg.sv =====
// ----------------------------------------------------------------------------
// seg7d_pkg
// Shared types, codes and constants of the seven-segment number display.
// ----------------------------------------------------------------------------
package seg7d_pkg;

   // Command field of an input word
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Digit codes held per position
   localparam logic [7:0] CODE_BLANK = 8'hff;
   localparam logic [7:0] CODE_MINUS = 8'h80;
   localparam logic [7:0] CODE_F     = 8'h0f;

   // Segment drive patterns
   localparam logic [7:0] SEG_MINUS = 8'h40;
   localparam logic [7:0] SEG_OFF   = 8'h00;

   // Configuration register
   localparam logic [7:0] PERIOD_RESET    = 8'd5;
   localparam logic       CSR_REG_REFRESH = 1'b0;

   // Display range
   localparam logic signed [31:0] VALUE_MAX = 32'sd9999;
   localparam logic signed [31:0] VALUE_MIN = -32'sd999;

   // Magnitude width once the value is known to be in range (<= 9999)
   localparam int MAG_W  = 14;
   localparam int PROD_W = 30;

   // Reciprocals: exact quotients for every magnitude below 2**14
   localparam logic [15:0] RECIP_10   = 16'd52429;  // >> 19
   localparam logic [15:0] RECIP_100  = 16'd5243;   // >> 19
   localparam logic [15:0] RECIP_1000 = 16'd8389;   // >> 23

   // Converted word passed from the conversion stage to the scan stage
   typedef struct packed {
      logic             valid;
      logic             cmd;
      logic             neg;
      logic             over;
      logic             under;
      logic [MAG_W-1:0] mag;
      logic [9:0]       q10;
      logic [6:0]       q100;
      logic [3:0]       q1000;
   } conv_type;

   // Hex digit to segments a..g
   function automatic logic [7:0] hex_segments(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'h0: seg = 8'h3f;
         4'h1: seg = 8'h06;
         4'h2: seg = 8'h5b;
         4'h3: seg = 8'h4f;
         4'h4: seg = 8'h66;
         4'h5: seg = 8'h6d;
         4'h6: seg = 8'h7d;
         4'h7: seg = 8'h07;
         4'h8: seg = 8'h7f;
         4'h9: seg = 8'h6f;
         4'ha: seg = 8'h77;
         4'hb: seg = 8'h7c;
         4'hc: seg = 8'h39;
         4'hd: seg = 8'h5e;
         4'he: seg = 8'h79;
         4'hf: seg = 8'h71;
         default: seg = SEG_OFF;
      endcase
      return seg;
   endfunction

endpackage

// ===== rtl/core/seven_segment_number_display.sv =====
// ----------------------------------------------------------------------------
// seven_segment_number_display
// Time-multiplexed four-digit common-cathode seven-segment driver.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_stall): one word per event. req_cmd = 0 is a
//    one millisecond tick, req_cmd = 1 loads req_value (signed) for display.
//  - rsp channel (rsp_valid/rsp_stall): one word per request, carrying the
//    held digit select and segment drive after that request took effect.
//  - csr port (APB style, always ready): refresh_period at address 0, the
//    number of ticks between scan steps.
//  - A request passes the input, conversion and result registers; one is
//    taken every cycle while rsp_stall is low. The decimal split uses three
//    reciprocal multipliers in the conversion stage; scan updates state.
//  - A stalled result holds its value; the two earlier stages keep taking
//    requests until they fill, then req_stall rises.
//  - Reset (synchronous) clears the pipeline, shows 0000 in the code store,
//    drives no digit and sets refresh_period to 5.
// ----------------------------------------------------------------------------
module seven_segment_number_display (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic signed [31:0]  req_value,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_digit_select,
   output logic [7:0]          rsp_segments,
   // configuration
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic [7:0]           refresh_period_ff, refresh_period_in;
   logic                 csr_write;
   logic                 scan_ready;
   seg7d_pkg::conv_type  conv;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == seg7d_pkg::CSR_REG_REFRESH);
   assign refresh_period_in = csr_write ? csr_pwdata[7:0] : refresh_period_ff;
   assign csr_prdata = (csr_paddr[2] == seg7d_pkg::CSR_REG_REFRESH)
                       ? {24'h000000, refresh_period_ff} : 32'h00000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_period_ff <= seg7d_pkg::PERIOD_RESET;
      end else begin
         refresh_period_ff <= refresh_period_in;
      end
   end

   seg7d_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .scan_ready (scan_ready),
      .conv       (conv)
   );

   seg7d_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .conv             (conv),
      .scan_ready       (scan_ready),
      .refresh_period   (refresh_period_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments)
   );

endmodule

// ===== rtl/core/seg7d_conv.sv =====
// ----------------------------------------------------------------------------
// seg7d_conv
// Input register and decimal split: range check, magnitude and the three
// reciprocal quotients of the magnitude, registered for the scan stage.
// ----------------------------------------------------------------------------
module seg7d_conv (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic signed [31:0]   req_value,
   input  logic                 scan_ready,
   output seg7d_pkg::conv_type  conv
);

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_cmd_ff;
   logic signed [31:0]   in_value_ff;

   // Conversion register
   seg7d_pkg::conv_type  conv_ff, conv_in;

   logic                 conv_free;
   logic                 in_move;
   logic                 in_free;
   logic                 req_take;
   logic                 neg;
   logic [seg7d_pkg::MAG_W-1:0]  mag;
   logic [seg7d_pkg::PROD_W-1:0] prod10, prod100, prod1000;

   // Stage flow: a stage takes a word when it is empty or its word moves on
   assign conv_free = !conv_ff.valid || scan_ready;
   assign in_move   = in_valid_ff && conv_free;
   assign in_free   = !in_valid_ff || conv_free;
   assign req_stall = !in_free;
   assign req_take  = req_valid && in_free;

   assign in_valid_in = req_take ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);

   // Magnitude: only the low bits matter once the value is in range
   assign neg = in_value_ff[31];
   assign mag = neg ? (~in_value_ff[seg7d_pkg::MAG_W-1:0] + 14'd1)
                    : in_value_ff[seg7d_pkg::MAG_W-1:0];

   // Reciprocal multiplies, one per decimal place
   assign prod10   = seg7d_pkg::PROD_W'(mag) * seg7d_pkg::PROD_W'(seg7d_pkg::RECIP_10);
   assign prod100  = seg7d_pkg::PROD_W'(mag) * seg7d_pkg::PROD_W'(seg7d_pkg::RECIP_100);
   assign prod1000 = seg7d_pkg::PROD_W'(mag) * seg7d_pkg::PROD_W'(seg7d_pkg::RECIP_1000);

   always_comb begin
      conv_in       = conv_ff;
      conv_in.valid = in_move ? 1'b1 : ((conv_ff.valid && scan_ready) ? 1'b0 : conv_ff.valid);
      if (in_move) begin
         conv_in.cmd   = in_cmd_ff;
         conv_in.neg   = neg;
         conv_in.over  = !neg && (in_value_ff > seg7d_pkg::VALUE_MAX);
         conv_in.under = neg && (in_value_ff < seg7d_pkg::VALUE_MIN);
         conv_in.mag   = mag;
         conv_in.q10   = prod10[28:19];
         conv_in.q100  = prod100[25:19];
         conv_in.q1000 = prod1000[26:23];
      end
   end

   // Control state and conversion register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         conv_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         conv_ff     <= conv_in;
      end
   end

   // Input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_cmd;
         in_value_ff <= req_value;
      end
   end

   assign conv = conv_ff;

endmodule

// ===== rtl/core/seg7d_scan.sv =====
// ----------------------------------------------------------------------------
// seg7d_scan
// Digit code store, tick divider and scan position; the held drive doubles
// as the result register.
// ----------------------------------------------------------------------------
module seg7d_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  seg7d_pkg::conv_type  conv,
   output logic                 scan_ready,
   input  logic [7:0]           refresh_period,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_digit_select,
   output logic [7:0]           rsp_segments
);

   logic [7:0] digit_codes_ff [4];
   logic [7:0] digit_codes_in [4];
   logic [7:0] tick_divider_ff, tick_divider_in;
   logic [1:0] scan_pos_ff, scan_pos_in;
   logic [3:0] held_select_ff, held_select_in;
   logic [7:0] held_segments_ff, held_segments_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       take;
   logic       do_load;
   logic       do_tick;
   logic       scan_fire;
   logic [8:0] tick_next;
   logic [3:0] d0, d1, d2;
   logic [13:0] d0_full;
   logic [9:0]  d1_full;
   logic [6:0]  d2_full;
   logic [7:0]  new_codes [4];
   logic [7:0]  cur_code;

   // Result register frees when empty or taken
   assign scan_ready = !rsp_valid_ff || !rsp_stall;
   assign take       = conv.valid && scan_ready;
   assign do_load    = take && (conv.cmd == seg7d_pkg::CMD_LOAD);
   assign do_tick    = take && (conv.cmd == seg7d_pkg::CMD_TICK);

   assign rsp_valid_in = take ? 1'b1 : (scan_ready ? 1'b0 : rsp_valid_ff);

   // Remainders from the registered quotients
   assign d0_full = conv.mag - (14'({conv.q10, 3'b000}) + 14'({conv.q10, 1'b0}));
   assign d1_full = conv.q10 - (10'({conv.q100, 3'b000}) + 10'({conv.q100, 1'b0}));
   assign d2_full = conv.q100 - (7'({conv.q1000, 3'b000}) + 7'({conv.q1000, 1'b0}));
   assign d0 = d0_full[3:0];
   assign d1 = d1_full[3:0];
   assign d2 = d2_full[3:0];

   // New digit codes: overflow, underflow or blanked decimal with minus
   always_comb begin
      if (conv.over) begin
         for (int i = 0; i < 4; i++) begin
            new_codes[i] = seg7d_pkg::CODE_F;
         end
      end else if (conv.under) begin
         new_codes[0] = seg7d_pkg::CODE_F;
         new_codes[1] = seg7d_pkg::CODE_F;
         new_codes[2] = seg7d_pkg::CODE_F;
         new_codes[3] = seg7d_pkg::CODE_MINUS;
      end else begin
         new_codes[0] = {4'h0, d0};
         new_codes[1] = (conv.q10 == '0)   ? seg7d_pkg::CODE_BLANK : {4'h0, d1};
         new_codes[2] = (conv.q100 == '0)  ? seg7d_pkg::CODE_BLANK : {4'h0, d2};
         new_codes[3] = (conv.q1000 == '0) ? seg7d_pkg::CODE_BLANK : {4'h0, conv.q1000};
         // minus goes in the first blank place
         if (conv.neg) begin
            if (conv.q10 == '0) begin
               new_codes[1] = seg7d_pkg::CODE_MINUS;
            end else if (conv.q100 == '0) begin
               new_codes[2] = seg7d_pkg::CODE_MINUS;
            end else begin
               new_codes[3] = seg7d_pkg::CODE_MINUS;
            end
         end
      end
   end

   // Tick divider and scan
   assign tick_next = {1'b0, tick_divider_ff} + 9'd1;
   assign scan_fire = do_tick && (tick_next >= {1'b0, refresh_period});
   assign cur_code  = digit_codes_ff[scan_pos_ff];

   always_comb begin
      tick_divider_in  = tick_divider_ff;
      scan_pos_in      = scan_pos_ff;
      held_select_in   = held_select_ff;
      held_segments_in = held_segments_ff;
      for (int i = 0; i < 4; i++) begin
         digit_codes_in[i] = do_load ? new_codes[i] : digit_codes_ff[i];
      end
      if (do_tick) begin
         tick_divider_in = scan_fire ? 8'd0 : tick_next[7:0];
      end
      if (scan_fire) begin
         scan_pos_in = scan_pos_ff + 2'd1;
         if (cur_code == seg7d_pkg::CODE_BLANK) begin
            held_select_in   = 4'b0000;
            held_segments_in = seg7d_pkg::SEG_OFF;
         end else begin
            held_select_in   = 4'b0001 << scan_pos_ff;
            held_segments_in = cur_code[7] ? seg7d_pkg::SEG_MINUS
                                           : seg7d_pkg::hex_segments(cur_code[3:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            digit_codes_ff[i] <= 8'h00;
         end
         tick_divider_ff  <= 8'd0;
         scan_pos_ff      <= 2'd0;
         held_select_ff   <= 4'b0000;
         held_segments_ff <= seg7d_pkg::SEG_OFF;
         rsp_valid_ff     <= 1'b0;
      end else begin
         digit_codes_ff   <= digit_codes_in;
         tick_divider_ff  <= tick_divider_in;
         scan_pos_ff      <= scan_pos_in;
         held_select_ff   <= held_select_in;
         held_segments_ff <= held_segments_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_select = held_select_ff;
   assign rsp_segments     = held_segments_ff;

`ifndef ASSERT_OFF
   // at most one digit driven
   a_select_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(held_select_ff))
      else $error("more than one digit driven");

   // dark digit means dark segments
   a_dark_blank: assert property (@(posedge clock) disable iff (reset)
      (held_select_ff == 4'b0000) |-> (held_segments_ff == seg7d_pkg::SEG_OFF))
      else $error("segments lit with no digit selected");

   // a load never moves the held drive
   a_load_holds: assert property (@(posedge clock) disable iff (reset)
      do_load |=> ($stable(held_select_ff) && $stable(held_segments_ff)
                   && $stable(scan_pos_ff)))
      else $error("load changed the held drive");

   // each scan steps the position by one
   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      scan_fire |=> (scan_pos_ff == $past(scan_pos_ff) + 2'd1))
      else $error("scan position did not advance");

   // a word accepted here always shows up as a result
   a_take_result: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("accepted word produced no result");
`endif

endmodule

// ===== tb/tb_seven_segment_number_display.sv =====
// ----------------------------------------------------------------------------
// tb_seven_segment_number_display
// Self-checking bench for the multiplexed four-digit seven-segment driver.
// Drives tick and load words with random gaps and result stalls, and sweeps
// the refresh period through several values, the extremes among them. A
// tracker class keeps its own copy of the digit codes and scan state, predicts
// the held drive after every word and compares it with each result word.
// ----------------------------------------------------------------------------
module tb_seven_segment_number_display;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] PERIOD_ADDR = {seg7d_pkg::CSR_REG_REFRESH, 2'b00};
   localparam logic [7:0] HEX_SEG [16] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
      8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
   };
   localparam int PHASES = 9;

   typedef struct packed {
      logic [3:0] digit_select;
      logic [7:0] segments;
   } drive_word_type;

   // Tracks the display state and the drive words still to come
   class display_drive_tracker;
      logic [7:0]     period;
      logic [7:0]     codes [4];
      logic [7:0]     divider;
      logic [1:0]     position;
      drive_word_type held;
      drive_word_type expected_drive_q [$];
      int             errors;

      function new();
         period   = seg7d_pkg::PERIOD_RESET;
         foreach (codes[i]) codes[i] = 8'h00;
         divider  = 8'h00;
         position = 2'd0;
         held     = '0;
         errors   = 0;
      endfunction

      function void set_period(input logic [7:0] p);
         period = p;
      endfunction

      function int pending();
         return expected_drive_q.size();
      endfunction

      // Signed number to digit codes, position 0 rightmost
      function void load_number(input logic [31:0] v);
         logic        neg;
         logic [31:0] mag;
         bit          placed;
         neg    = v[31];
         mag    = neg ? (32'd0 - v) : v;
         placed = 1'b0;
         if (!neg && v > 32'd9999) begin
            foreach (codes[i]) codes[i] = seg7d_pkg::CODE_F;
         end else if (neg && mag > 32'd999) begin
            for (int i = 0; i < 3; i++) codes[i] = seg7d_pkg::CODE_F;
            codes[3] = seg7d_pkg::CODE_MINUS;
         end else begin
            for (int i = 0; i < 4; i++) begin
               if (mag == 0 && i != 0) codes[i] = seg7d_pkg::CODE_BLANK;
               else codes[i] = 8'(mag % 10);
               mag = mag / 10;
            end
            // minus goes in the first blank position
            if (neg) begin
               for (int i = 0; i < 4; i++) begin
                  if (!placed && codes[i] == seg7d_pkg::CODE_BLANK) begin
                     codes[i] = seg7d_pkg::CODE_MINUS;
                     placed   = 1'b1;
                  end
               end
            end
         end
      endfunction

      // Drive the current position, then advance
      function void scan_next();
         logic [7:0] code;
         code = codes[position];
         if (code == seg7d_pkg::CODE_BLANK) begin
            held = '0;
         end else begin
            held.digit_select = 4'(1) << position;
            held.segments = ((code & seg7d_pkg::CODE_MINUS) != 0)
                            ? seg7d_pkg::SEG_MINUS : HEX_SEG[code[3:0]];
         end
         position = position + 2'd1;
      endfunction

      function void note_word(input logic cmd, input logic [31:0] value);
         logic [8:0] next;
         if (cmd == seg7d_pkg::CMD_LOAD) begin
            load_number(value);
         end else begin
            next = {1'b0, divider} + 9'd1;
            if (next >= {1'b0, period}) begin
               divider = 8'h00;
               scan_next();
            end else begin
               divider = next[7:0];
            end
         end
         expected_drive_q.push_back(held);
      endfunction

      function void check_drive(input logic [3:0] sel, input logic [7:0] seg);
         drive_word_type exp_w;
         if (expected_drive_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, select %h segments %h", $time, sel, seg);
            return;
         end
         exp_w = expected_drive_q.pop_front();
         if (sel !== exp_w.digit_select) begin
            errors++;
            $display("%0t: digit_select expected %h actual %h",
                     $time, exp_w.digit_select, sel);
         end
         if (seg !== exp_w.segments) begin
            errors++;
            $display("%0t: segments expected %h actual %h", $time, exp_w.segments, seg);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = seg7d_pkg::CMD_TICK;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_digit_select;
   logic [7:0]         rsp_segments;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   bit                 quiet = 1'b0;
   display_drive_tracker tracker = new();

   seven_segment_number_display dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Load values weighted toward the decimal range and its edges
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom;
      if (r < 16) begin
         case ($urandom_range(0, 8))
            0: return 32'd0;
            1: return 32'd9999;
            2: return 32'd10000;
            3: return -32'sd999;
            4: return -32'sd1000;
            5: return 32'h7fff_ffff;
            6: return 32'h8000_0000;
            7: return -32'sd1;
            default: return 32'd1;
         endcase
      end
      if (r < 45) return $urandom_range(0, 9999);
      if (r < 65) return 32'd0 - $urandom_range(1, 999);
      if (r < 72) return $urandom_range(0, 99);
      if (r < 78) return 32'd0 - $urandom_range(1, 99);
      if (r < 84) return $urandom_range(9990, 10010);
      if (r < 90) return 32'd0 - $urandom_range(990, 1010);
      if (r < 95) return $urandom_range(10000, 32'h7fff_ffff);
      return 32'd0 - $urandom_range(1000, 32'h8000_0000);
   endfunction

   // Send one word; returns at the falling edge after acceptance
   task automatic send_word(input logic cmd, input logic [31:0] value);
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pause_req(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic send_tick();
      send_word(seg7d_pkg::CMD_TICK, $urandom);
   endtask

   // Setup then access cycle; register written at the access edge
   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drain the pipe, then change the period
   task automatic change_period(input logic [7:0] p);
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_csr(PERIOD_ADDR, {24'($urandom), p});
   endtask

   // Result-side stall pattern
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = pick_gap();
         rsp_stall <= 1'b0;
         repeat (n + 1) @(negedge clock);
         if (!quiet) begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
            end
         end
      end
   end

   // Observe accepted words, register writes and results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == PERIOD_ADDR)
            tracker.set_period(csr_pwdata[7:0]);
         if (req_valid && !req_stall)
            tracker.note_word(req_cmd, req_value);
         if (rsp_valid && !rsp_stall)
            tracker.check_drive(rsp_digit_select, rsp_segments);
      end
   end

   // Stimulus
   initial begin
      logic [7:0] period;
      int         count;
      int         tick_pct;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset period: fifth tick scans position 0 of 0000
      repeat (5) send_tick();

      // one scan per tick; zero, minus placement, overflow, underflow
      change_period(8'd1);
      send_word(seg7d_pkg::CMD_LOAD, 32'd0);
      repeat (3) send_tick();
      send_word(seg7d_pkg::CMD_LOAD, -32'sd7);
      repeat (2) send_tick();
      send_word(seg7d_pkg::CMD_LOAD, 32'd10000);
      send_tick();
      send_word(seg7d_pkg::CMD_LOAD, -32'sd1000);
      send_tick();
      send_word(seg7d_pkg::CMD_LOAD, 32'd9999);
      send_tick();
      send_word(seg7d_pkg::CMD_LOAD, 32'h7fff_ffff);
      send_word(seg7d_pkg::CMD_LOAD, 32'h8000_0000);
      send_tick();
      send_word(seg7d_pkg::CMD_LOAD, -32'sd999);
      send_tick();
      send_word(seg7d_pkg::CMD_LOAD, -32'sd100);
      repeat (2) send_tick();

      // period lowered below the running count scans on the next tick
      change_period(8'd200);
      repeat (8) send_tick();
      change_period(8'd3);
      send_tick();

      // random phases over several periods
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: period = 8'd0;
            1: period = 8'd1;
            2: period = 8'd255;
            3: period = 8'd2;
            default: period = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                          : 8'($urandom_range(1, 6));
         endcase
         change_period(period);
         quiet    = (p % 3 == 1);
         count    = (period == 8'd255) ? 450 : 150;
         tick_pct = (period == 8'd255) ? 95 : 70;
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < tick_pct) send_tick();
            else send_word(seg7d_pkg::CMD_LOAD, pick_value());
            if (!quiet) pause_req(pick_gap());
         end
      end
      quiet = 1'b0;

      // drain and settle
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("seven_segment_number_display test passed");
      end else begin
         $display("seven_segment_number_display test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("seven_segment_number_display test failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/seg7d_pkg.sv
rtl/core/seg7d_conv.sv
rtl/core/seg7d_scan.sv
rtl/core/seven_segment_number_display.sv
tb/tb_seven_segment_number_display.sv
